[src/hatb_pkg.sv]
// ---------------------------------------------------------------------------
// hatb_pkg
// Shared types, constants and the hex digit decoder for the ascii hex decoder.
// ---------------------------------------------------------------------------
package hatb_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned NIB_W   = 4;

    localparam logic [CHAR_W-1:0] UPPER_OFFSET = 8'h37;
    localparam logic [CHAR_W-1:0] LOWER_OFFSET = 8'h57;
    localparam logic [CHAR_W-1:0] NIB_MASK_HI  = 8'hF0;

    localparam logic [COUNT_W-1:0] MAX_BYTES_RESET = 7'd127;

    // tdata width: out_byte and byte_count, padded to whole bytes
    localparam int unsigned M_TDATA_W = 16;
    localparam int unsigned M_TUSER_W = 3;

    // register index of max_bytes
    localparam logic REG_MAX_BYTES = 1'b0;

    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic               ok;
        logic               done_res;
        logic               byte_valid;
        logic [CHAR_W-1:0]  out_byte;
    } result_t;

    typedef struct packed {
        logic             hit;
        logic [NIB_W-1:0] nib;
    } nib_dec_t;

    function automatic nib_dec_t decode_hex(input logic [CHAR_W-1:0] ch);
        nib_dec_t             d;
        logic [CHAR_W-1:0]    diff;
        d    = '0;
        diff = '0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            diff  = ch - 8'h30;
            d.hit = 1'b1;
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            diff  = ch - UPPER_OFFSET;
            d.hit = 1'b1;
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            diff  = ch - LOWER_OFFSET;
            d.hit = 1'b1;
        end
        d.nib = diff[NIB_W-1:0];
        return d;
    endfunction

endpackage

[src/hex_ascii_to_bytes_top.sv]
// ---------------------------------------------------------------------------
// hex_ascii_to_bytes_top
// Streaming ascii hex to binary decoder, one character per transaction.
// ---------------------------------------------------------------------------
//
//  channel   | direction | transaction carries
//  ----------+-----------+----------------------------------------------------
//  s_axis    | in        | tdata[7:0] char_code, tlast string_end
//  m_axis    | out       | tdata out_byte/byte_count, tuser valid/done/ok flags
//  apb       | in/out    | max_bytes at byte address 0
//
//  one input transaction per cycle while s_axis_tready is high, one result transaction per input
//  each result is registered in the output register, or in the skid entry when
//  m_axis stalls; the decode and state update loop runs on second_nibble,
//  high_nibble, bytes_done and discarding
//  output register plus one skid entry: s_axis_tready is registered and only
//  drops when both hold results that m_axis has not taken
//  aresetn is synchronous active low; max_bytes resets to 127
//
module hex_ascii_to_bytes_top
    import hatb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [CHAR_W-1:0]    s_axis_tdata,   // [7:0] char_code
    input  logic                 s_axis_tlast,   // string_end

    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // [7:0] out_byte, [14:8] byte_count
    output logic [M_TUSER_W-1:0] m_axis_tuser,   // [0] byte_valid, [1] done_res, [2] ok

    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // conversion state
    logic               second_nibble_reg, second_nibble_next;
    logic [NIB_W-1:0]   high_nibble_reg,   high_nibble_next;
    logic [COUNT_W-1:0] bytes_done_reg,    bytes_done_next;
    logic               discarding_reg,    discarding_next;
    logic [COUNT_W-1:0] max_bytes_reg;

    // output register and skid entry
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;

    result_t            res;
    nib_dec_t           dec;
    logic               in_accept;
    logic               out_pop;
    logic [CHAR_W-1:0]  partial;
    logic [COUNT_W-1:0] count_inc;
    logic               limit_met;
    logic               cfg_write;

    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_pop       = out_valid_reg && m_axis_tready;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_BYTES_RESET;
        end else if (cfg_write && paddr[2] == REG_MAX_BYTES) begin
            max_bytes_reg <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_BYTES) begin
            prdata[COUNT_W-1:0] = max_bytes_reg;
        end
    end

    // ---------------- decode step ----------------
    assign dec       = decode_hex(s_axis_tdata);
    assign partial   = {high_nibble_reg, {NIB_W{1'b0}}} & NIB_MASK_HI;
    assign count_inc = bytes_done_reg + 7'd1;
    assign limit_met = bytes_done_reg >= max_bytes_reg;

    always_comb begin
        res                = '0;
        second_nibble_next = second_nibble_reg;
        high_nibble_next   = high_nibble_reg;
        bytes_done_next    = bytes_done_reg;
        discarding_next    = discarding_reg;

        priority if (discarding_reg) begin
            // drop everything until the string end, which re-arms
            if (s_axis_tlast) begin
                second_nibble_next = 1'b0;
                high_nibble_next   = '0;
                bytes_done_next    = '0;
                discarding_next    = 1'b0;
            end
        end else if (!second_nibble_reg && limit_met) begin
            // limit already reached at the start of a pair
            res.done_res   = 1'b1;
            res.ok         = 1'b1;
            res.byte_count = bytes_done_reg;
            if (s_axis_tlast) begin
                bytes_done_next = '0;
            end else begin
                discarding_next = 1'b1;
            end
        end else if (s_axis_tlast) begin
            res.done_res = 1'b1;
            if (second_nibble_reg) begin
                // odd end: flush the half byte and fail
                res.out_byte   = partial;
                res.byte_valid = 1'b1;
                res.byte_count = count_inc;
            end else begin
                res.ok         = 1'b1;
                res.byte_count = bytes_done_reg;
            end
            second_nibble_next = 1'b0;
            high_nibble_next   = '0;
            bytes_done_next    = '0;
        end else if (!dec.hit) begin
            // invalid character
            res.done_res = 1'b1;
            if (second_nibble_reg) begin
                res.out_byte   = partial;
                res.byte_valid = 1'b1;
                res.byte_count = count_inc;
            end else begin
                res.byte_count = bytes_done_reg;
            end
            discarding_next = 1'b1;
        end else if (!second_nibble_reg) begin
            high_nibble_next   = dec.nib;
            second_nibble_next = 1'b1;
        end else begin
            // pair complete
            res.out_byte       = partial | {{NIB_W{1'b0}}, dec.nib};
            res.byte_valid     = 1'b1;
            second_nibble_next = 1'b0;
            high_nibble_next   = '0;
            bytes_done_next    = count_inc;
            if (count_inc >= max_bytes_reg) begin
                res.done_res    = 1'b1;
                res.ok          = 1'b1;
                res.byte_count  = count_inc;
                discarding_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            second_nibble_reg <= 1'b0;
            high_nibble_reg   <= '0;
            bytes_done_reg    <= '0;
            discarding_reg    <= 1'b0;
        end else if (in_accept) begin
            second_nibble_reg <= second_nibble_next;
            high_nibble_reg   <= high_nibble_next;
            bytes_done_reg    <= bytes_done_next;
            discarding_reg    <= discarding_next;
        end
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_accept;
            end
        end else if (in_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else begin
                out_reg <= res;
            end
        end else if (in_accept) begin
            skid_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.byte_count, out_reg.out_byte};
    assign m_axis_tuser  = {out_reg.ok, out_reg.done_res, out_reg.byte_valid};

endmodule

[src/hatb_checker.sv]
// ---------------------------------------------------------------------------
// hatb_checker
// Port-level checks for the ascii hex decoder, bound to the top level.
// ---------------------------------------------------------------------------
module hatb_checker
    import hatb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic [M_TUSER_W-1:0] m_axis_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic [31:0]          prdata
);

    // stalled result stays offered
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // count and ok only carried on the finishing transaction
    a_done_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[14:8] == 7'd0
            && !m_axis_tuser[2])
        else $error("count or ok set without done");

    // no byte value without byte_valid
    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
        else $error("byte value without byte_valid");

    // a write to max_bytes reads back on the next cycle
    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && !paddr[2]) ##1 !paddr[2]
            |-> prdata[COUNT_W-1:0] == $past(pwdata[COUNT_W-1:0]) && prdata[31:COUNT_W] == '0)
        else $error("max_bytes readback mismatch");

endmodule

bind hex_ascii_to_bytes_top hatb_checker u_hatb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);

[dv/hatb_tb_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hatb_tb_pkg
// Result tracker for the ascii hex decoder: a bit-exact copy of the decode
// state that predicts each result transaction, plus the in-order checker.
// ---------------------------------------------------------------------------
package hatb_tb_pkg;

    import hatb_pkg::*;

    class hex_decode_scoreboard;

        // decode state, kept at the block's widths
        logic               low_pending;
        logic [NIB_W-1:0]   held_nibble;
        logic [COUNT_W-1:0] bytes_made;
        logic               skipping;
        logic [COUNT_W-1:0] byte_limit;

        result_t expected_results[$];
        int      mismatches;

        function new();
            byte_limit = MAX_BYTES_RESET;
            mismatches = 0;
            clear_string();
        endfunction

        function void clear_string();
            low_pending = 1'b0;
            held_nibble = '0;
            bytes_made  = '0;
            skipping    = 1'b0;
        endfunction

        function void set_limit(input logic [COUNT_W-1:0] value);
            byte_limit = value;
        endfunction

        static function bit hex_value(input logic [CHAR_W-1:0] ch, output logic [NIB_W-1:0] nib);
            nib = '0;
            if (ch >= "0" && ch <= "9") begin
                nib = ch[3:0];
                return 1'b1;
            end
            if ((ch >= "A" && ch <= "F") || (ch >= "a" && ch <= "f")) begin
                nib = ch[3:0] + 4'd9;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // one character or string end through the decoder
        function result_t decode_char(input logic [CHAR_W-1:0] ch, input logic str_end);
            result_t          r;
            logic [NIB_W-1:0] nib;
            logic [CHAR_W-1:0] partial;
            r       = '0;
            partial = {held_nibble, 4'h0};
            if (skipping) begin
                if (str_end)
                    clear_string();
                return r;
            end
            if (!low_pending && bytes_made >= byte_limit) begin
                r.done_res   = 1'b1;
                r.ok         = 1'b1;
                r.byte_count = bytes_made;
                if (str_end)
                    clear_string();
                else
                    skipping = 1'b1;
                return r;
            end
            if (str_end) begin
                r.done_res = 1'b1;
                if (low_pending) begin
                    r.out_byte   = partial;
                    r.byte_valid = 1'b1;
                    r.byte_count = bytes_made + 1'b1;
                end else begin
                    r.ok         = 1'b1;
                    r.byte_count = bytes_made;
                end
                clear_string();
                return r;
            end
            if (!hex_value(ch, nib)) begin
                r.done_res = 1'b1;
                if (low_pending) begin
                    r.out_byte   = partial;
                    r.byte_valid = 1'b1;
                    r.byte_count = bytes_made + 1'b1;
                end else begin
                    r.byte_count = bytes_made;
                end
                skipping = 1'b1;
                return r;
            end
            if (!low_pending) begin
                held_nibble = nib;
                low_pending = 1'b1;
                return r;
            end
            r.out_byte   = {held_nibble, nib};
            r.byte_valid = 1'b1;
            low_pending  = 1'b0;
            held_nibble  = '0;
            bytes_made   = bytes_made + 1'b1;
            if (bytes_made >= byte_limit) begin
                r.done_res   = 1'b1;
                r.ok         = 1'b1;
                r.byte_count = bytes_made;
                skipping     = 1'b1;
            end
            return r;
        endfunction

        // accepted input; returns 1 when the item was not simply skipped
        function bit note_char(input logic [CHAR_W-1:0] ch, input logic str_end);
            bit live;
            live = !skipping;
            expected_results.push_back(decode_char(ch, str_end));
            return live;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function void compare_field(input string name, input longint unsigned exp_v,
                                    input longint unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing pending: 0x%0h", got);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("out_byte",   want.out_byte,   got.out_byte);
            compare_field("byte_valid", want.byte_valid, got.byte_valid);
            compare_field("done_res",   want.done_res,   got.done_res);
            compare_field("ok",         want.ok,         got.ok);
            compare_field("byte_count", want.byte_count, got.byte_count);
        endfunction

    endclass

endpackage

[dv/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stream-level test of hex_ascii_to_bytes_top: directed strings for digit and
// letter ranges, bad characters, odd ends and the byte limit, then random
// strings under three idle mixes, a long receiver hold-off and limit changes
// over the register port. Every result transaction is checked in order.
// ---------------------------------------------------------------------------
module tb;

    import hatb_pkg::*;
    import hatb_tb_pkg::*;

    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          HOLD_CYCLES    = 300;
    localparam logic [2:0]  MAX_BYTES_ADDR = {REG_MAX_BYTES, 2'b00};

    // characters just outside the hex ranges, plus the all-zero and all-one codes
    localparam logic [7:0] BOUNDARY_CHARS [8] = '{8'h00, 8'h2F, 8'h3A, 8'h40,
                                                  8'h47, 8'h60, 8'h67, 8'hFF};

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [CHAR_W-1:0]    s_axis_tdata;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    hex_decode_scoreboard sb;

    int send_idle_pct;
    int recv_idle_pct;
    int live_items;
    int hold_requests;
    int hold_served;
    int hold_left;
    int cycle_count;

    hex_ascii_to_bytes_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] char_code
        .s_axis_tlast  (s_axis_tlast),   // string_end
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte, [14:8] byte_count
        .m_axis_tuser  (m_axis_tuser),   // [0] byte_valid, [1] done_res, [2] ok
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 20 ns clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random idling, or a long hold-off when one is requested
    initial begin
        m_axis_tready = 1'b0;
        hold_served   = 0;
        hold_left     = 0;
        forever begin
            @(negedge aclk);
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // result transactions are checked at the edge that accepts them
    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got            = '0;
            got.out_byte   = m_axis_tdata[7:0];
            got.byte_count = m_axis_tdata[14:8];
            got.byte_valid = m_axis_tuser[0];
            got.done_res   = m_axis_tuser[1];
            got.ok         = m_axis_tuser[2];
            sb.check_result(got);
        end
    end

    function automatic logic [7:0] rand_hex_char();
        int unsigned v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return 8'(32'h30 + v);
        else if ($urandom_range(0, 1) != 0)
            return 8'(32'h41 + v - 10);
        else
            return 8'(32'h61 + v - 10);
    endfunction

    function automatic logic [7:0] rand_bad_char();
        logic [7:0] ch;
        logic [3:0] nib;
        if ($urandom_range(0, 1) != 0)
            return BOUNDARY_CHARS[$urandom_range(0, 7)];
        do
            ch = 8'($urandom_range(0, 255));
        while (hex_decode_scoreboard::hex_value(ch, nib));
        return ch;
    endfunction

    // one input transaction; tvalid stays high into the next call unless it idles
    task automatic send_item(input logic [7:0] ch, input logic str_end);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= str_end;
        do
            @(posedge aclk);
        while (!s_axis_tready);
        if (sb.note_char(ch, str_end))
            live_items++;
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // drop tvalid and wait for every pending result, then let the pipe settle
    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic apb_access(input logic is_write, input logic [31:0] wdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= MAX_BYTES_ADDR;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        if (!is_write)
            sb.compare_field("max_bytes readback", {25'd0, sb.byte_limit}, prdata);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // limit change, only with the block idle; read back afterwards
    task automatic set_max_bytes(input logic [COUNT_W-1:0] value);
        wait_drained();
        apb_access(1'b1, {25'd0, value});
        sb.set_limit(value);
        apb_access(1'b0, '0);
    endtask

    // well-formed strings, plus some odd, some with a bad character, some noise
    task automatic send_random_string(input int max_pairs);
        int kind;
        int n_chars;
        int bad_pos;
        int k;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            n_chars = $urandom_range(1, 6);
            for (k = 0; k < n_chars; k++)
                send_item(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
            return;
        end
        n_chars = 2 * $urandom_range(0, max_pairs) + ((kind < 35) ? 1 : 0);
        bad_pos = -1;
        if (kind >= 35 && kind < 55) begin
            if (n_chars == 0)
                n_chars = 1;
            bad_pos = $urandom_range(0, n_chars - 1);
        end
        for (k = 0; k < n_chars; k++)
            send_item((k == bad_pos) ? rand_bad_char() : rand_hex_char(), 1'b0);
        send_end();
    endtask

    task automatic random_phase(input int item_goal, input int max_pairs);
        while (live_items < item_goal)
            send_random_string(max_pairs);
    endtask

    initial begin
        int k;
        sb            = new();
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        send_idle_pct = 31;
        recv_idle_pct = 46;
        live_items    = 0;
        hold_requests = 0;
        cycle_count   = 0;

        // reset held, then released between edges
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // limit comes out of reset at its top value
        apb_access(1'b0, '0);

        // digit and letter range ends, both letter cases
        send_item("0", 1'b0);
        send_item("9", 1'b0);
        send_item("A", 1'b0);
        send_item("f", 1'b0);
        send_end();
        // odd end leaves a partial byte
        send_item("a", 1'b0);
        send_end();
        // bad first character, then the end is skipped
        send_item(8'h00, 1'b0);
        send_end();
        // bad second character, rest skipped until the end
        send_item("5", 1'b0);
        send_item("@", 1'b0);
        send_item("x", 1'b0);
        send_end();
        // empty string
        send_end();

        // limit reached on a completed pair
        set_max_bytes(7'd1);
        send_item("F", 1'b0);
        send_item("3", 1'b0);
        send_item("d", 1'b0);
        send_end();

        // zero limit: met on arrival, by a character and by an end
        set_max_bytes(7'd0);
        send_item("7", 1'b0);
        send_end();
        send_end();

        // limit lowered while a pair is half done: pair completes first
        set_max_bytes(7'd2);
        send_item("1", 1'b0);
        send_item("2", 1'b0);
        send_item("3", 1'b0);
        set_max_bytes(7'd1);
        send_item("4", 1'b0);
        send_end();

        // limit lowered at a pair boundary: next character not decoded
        set_max_bytes(7'd3);
        send_item("b", 1'b0);
        send_item("c", 1'b0);
        set_max_bytes(7'd1);
        send_item("e", 1'b0);
        send_end();

        // random strings, small limit, sender idles less than receiver
        set_max_bytes(7'd3);
        random_phase(100, 5);

        // top limit, receiver idles less; one string runs all the way to it
        send_idle_pct = 46;
        recv_idle_pct = 31;
        set_max_bytes(MAX_BYTES_RESET);
        for (k = 0; k < 254; k++)
            send_item(rand_hex_char(), 1'b0);
        send_end();
        random_phase(360, 8);

        // no idling; a long receiver hold-off fills the block and stalls input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_max_bytes(7'd6);
        hold_requests++;
        for (k = 0; k < 24; k++)
            send_item(rand_hex_char(), 1'b0);
        send_end();
        // sender waits for every result before going on
        wait_drained();
        random_phase(400, 8);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
